FILE: hw/rtl/dplp_pkg.sv
// Package for the decimal pair line parser: character codes, phase and status codes.
package dplp_pkg;

    localparam int ValueWidth = 31;
    localparam int CharWidth  = 8;

    localparam logic [ValueWidth-1:0] MaxMagnitude = {ValueWidth{1'b1}};

    localparam logic [CharWidth-1:0] ChSeparator = 8'h2C;
    localparam logic [CharWidth-1:0] ChPlus      = 8'h2B;
    localparam logic [CharWidth-1:0] ChMinus     = 8'h2D;
    localparam logic [CharWidth-1:0] ChZero      = 8'h30;
    localparam logic [CharWidth-1:0] ChNine      = 8'h39;
    localparam logic [CharWidth-1:0] ChSpace     = 8'h20;
    localparam logic [CharWidth-1:0] ChTab       = 8'h09;
    localparam logic [CharWidth-1:0] ChCr        = 8'h0D;

    // field phase codes
    localparam logic [2:0] PhLead   = 3'd0;
    localparam logic [2:0] PhSign   = 3'd1;
    localparam logic [2:0] PhDigits = 3'd2;
    localparam logic [2:0] PhTrail  = 3'd3;
    localparam logic [2:0] PhBad    = 3'd4;

    // side status codes
    localparam logic [1:0] StBlank   = 2'd0;
    localparam logic [1:0] StValid   = 2'd1;
    localparam logic [1:0] StInvalid = 2'd2;

    // C-locale whitespace: space, TAB..CR
    function automatic logic is_blank(input logic [CharWidth-1:0] c);
        is_blank = (c == ChSpace) || (c >= ChTab && c <= ChCr);
    endfunction

    function automatic logic is_digit(input logic [CharWidth-1:0] c);
        is_digit = (c >= ChZero) && (c <= ChNine);
    endfunction

endpackage

FILE: hw/rtl/decimal_pair_line_parser.sv
// Decimal pair line parser: splits a text line at its first comma, reads two integers.
// Words are parsed from the input register; end-of-line words load the result register.
// Throughput: one word per cycle unless an end-of-line word meets a full result
//   slot; the per-character multiply-by-ten add and phase update sit between the
//   input register and the parser state.
// Reset: aresetn (synchronous, active low) empties both registers and returns
//   the parser to the start of a line.
module decimal_pair_line_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [30:0] source_value, [61:31] dest_value, [63:62] zero
    output logic [1:0]  m_tuser    // [0] line_valid, [1] dest_present
);
    import dplp_pkg::*;

    // input register
    logic                  in_valid_reg;
    logic                  in_last_reg;
    logic [CharWidth-1:0]  in_char_reg;

    // parser state
    logic                  after_comma_reg,  after_comma_next;
    logic [2:0]            phase_reg,        phase_next;
    logic                  minus_reg,        minus_next;
    logic [ValueWidth-1:0] acc_reg,          acc_next;
    logic                  ovf_reg,          ovf_next;
    logic [1:0]            first_status_reg, first_status_next;
    logic [ValueWidth-1:0] first_value_reg,  first_value_next;

    // result register
    logic                  m_valid_reg;
    logic                  line_valid_reg,   line_valid_next;
    logic                  dest_present_reg, dest_present_next;
    logic [ValueWidth-1:0] src_reg,          src_next;
    logic [ValueWidth-1:0] dst_reg,          dst_next;

    logic                  advance;
    logic                  out_load;
    logic [1:0]            side_st;
    logic [ValueWidth-1:0] digit_val;
    logic [ValueWidth+3:0] acc_x10;

    // a character always moves on; an end-of-line word waits for a free result slot
    assign out_load = in_valid_reg && in_last_reg;
    assign advance  = in_valid_reg && (!in_last_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign digit_val = ValueWidth'(in_char_reg - ChZero);
    // acc * 10 as (acc << 3) + (acc << 1), plus the new digit
    assign acc_x10 = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + {4'b0000, digit_val};

    // status of the side being read now
    always_comb begin
        if (phase_reg == PhLead) begin
            side_st = StBlank;
        end else if (phase_reg != PhDigits && phase_reg != PhTrail) begin
            side_st = StInvalid;
        end else if (ovf_reg) begin
            side_st = StInvalid;
        end else if (minus_reg && acc_reg != '0) begin
            side_st = StInvalid;
        end else begin
            side_st = StValid;
        end
    end

    always_comb begin
        after_comma_next  = after_comma_reg;
        phase_next        = phase_reg;
        minus_next        = minus_reg;
        acc_next          = acc_reg;
        ovf_next          = ovf_reg;
        first_status_next = first_status_reg;
        first_value_next  = first_value_reg;
        line_valid_next   = 1'b0;
        dest_present_next = 1'b0;
        src_next          = '0;
        dst_next          = '0;

        if (in_last_reg) begin
            // end of line: build the result, then back to the start of a line
            if (after_comma_reg && first_status_reg == StValid) begin
                if (side_st == StBlank) begin
                    line_valid_next = 1'b1;
                    src_next        = first_value_reg;
                end else if (side_st == StValid) begin
                    line_valid_next   = 1'b1;
                    src_next          = first_value_reg;
                    dest_present_next = 1'b1;
                    dst_next          = acc_reg;
                end
            end
            after_comma_next  = 1'b0;
            phase_next        = PhLead;
            minus_next        = 1'b0;
            acc_next          = '0;
            ovf_next          = 1'b0;
            first_status_next = StBlank;
            first_value_next  = '0;
        end else if (in_char_reg == ChSeparator && !after_comma_reg) begin
            // first comma closes the source side
            first_status_next = side_st;
            first_value_next  = acc_reg;
            after_comma_next  = 1'b1;
            phase_next        = PhLead;
            minus_next        = 1'b0;
            acc_next          = '0;
            ovf_next          = 1'b0;
        end else begin
            case (phase_reg)
                PhLead: begin
                    if (is_blank(in_char_reg)) begin
                        phase_next = PhLead;
                    end else if (in_char_reg == ChPlus) begin
                        phase_next = PhSign;
                    end else if (in_char_reg == ChMinus) begin
                        minus_next = 1'b1;
                        phase_next = PhSign;
                    end else if (is_digit(in_char_reg)) begin
                        phase_next = PhDigits;
                        acc_next   = digit_val;
                    end else begin
                        phase_next = PhBad;
                    end
                end
                PhSign: begin
                    if (is_digit(in_char_reg)) begin
                        phase_next = PhDigits;
                        acc_next   = digit_val;
                    end else begin
                        phase_next = PhBad;
                    end
                end
                PhDigits: begin
                    if (is_digit(in_char_reg)) begin
                        // saturate once the magnitude passes the 31-bit limit
                        if (acc_x10[ValueWidth+3:ValueWidth] != '0) begin
                            ovf_next = 1'b1;
                            acc_next = MaxMagnitude;
                        end else begin
                            acc_next = acc_x10[ValueWidth-1:0];
                        end
                    end else if (is_blank(in_char_reg)) begin
                        phase_next = PhTrail;
                    end else begin
                        phase_next = PhBad;
                    end
                end
                PhTrail: begin
                    if (!is_blank(in_char_reg)) begin
                        phase_next = PhBad;
                    end
                end
                default: begin
                    phase_next = PhBad;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_last_reg <= s_tlast;
            in_char_reg <= s_tdata;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            after_comma_reg  <= 1'b0;
            phase_reg        <= PhLead;
            minus_reg        <= 1'b0;
            acc_reg          <= '0;
            ovf_reg          <= 1'b0;
            first_status_reg <= StBlank;
            first_value_reg  <= '0;
        end else if (advance) begin
            after_comma_reg  <= after_comma_next;
            phase_reg        <= phase_next;
            minus_reg        <= minus_next;
            acc_reg          <= acc_next;
            ovf_reg          <= ovf_next;
            first_status_reg <= first_status_next;
            first_value_reg  <= first_value_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && out_load) begin
            line_valid_reg   <= line_valid_next;
            dest_present_reg <= dest_present_next;
            src_reg          <= src_next;
            dst_reg          <= dst_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, dst_reg, src_reg};
    assign m_tuser  = {dest_present_reg, line_valid_reg};

endmodule

FILE: tb/decimal_pair_line_parser_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for decimal_pair_line_parser: directed and random lines scored by a behavioural parser.
module decimal_pair_line_parser_tb;
    import dplp_pkg::*;

    localparam int ClkPeriod     = 10;
    localparam int RandomWords   = 1700;
    localparam int IdlePercent   = 14;
    localparam int DrainCycles   = 20;      // extra wait once no line is outstanding; ample margin
    localparam int TimeoutCycles = 400000;  // watchdog limit, in clock periods
    localparam int DirectedRows  = 29;
    localparam int SteadyFrom    = DirectedRows + 600;
    localparam int SteadyTo      = DirectedRows + 900;

    // one parsed line as the result channel carries it
    typedef struct packed {
        logic                  ok;
        logic [ValueWidth-1:0] src;
        logic                  has_dst;
        logic [ValueWidth-1:0] dst;
    } parsed_line_t;

    // one row of the directed table; want only counts on end-of-line rows with typed set
    typedef struct packed {
        logic                 last;
        logic [CharWidth-1:0] ch;
        logic                 typed;
        parsed_line_t         want;
    } stim_row_t;

    typedef struct packed {
        logic         typed;
        parsed_line_t want;
    } typed_line_t;

    typedef enum logic [2:0] {ClsBlank, ClsDigit, ClsPlus, ClsMinus, ClsOther} char_class_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // [7:0] char_code
    logic        s_tlast  = 1'b0;  // is_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [30:0] source_value, [61:31] dest_value, [63:62] zero
    logic [1:0]  m_tuser;          // [0] line_valid, [1] dest_present

    // both sides stop idling while this is set
    logic steady = 1'b0;

    // lines whose end word has been accepted, oldest first
    parsed_line_t expected_lines[$];
    // one entry per end word driven: the table's typed answer, or a flag to use the parser's own
    typed_line_t  typed_answers[$];
    // characters of the random line being built
    logic [7:0]   line_chars[$];

    int failures      = 0;
    int words_sent    = 0;
    int lines_scored  = 0;
    int valid_lines   = 0;
    int dest_lines    = 0;

    // behavioural parser state
    logic                  past_comma;
    logic [2:0]            phase;
    logic                  negative;
    logic [ValueWidth-1:0] magnitude;
    logic                  too_big;
    logic [1:0]            src_status;
    logic [ValueWidth-1:0] src_value;

    decimal_pair_line_parser u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #(ClkPeriod / 2) aclk = ~aclk;

    // ---------------------------------------------------------------- parser model

    function automatic char_class_t classify(input logic [7:0] c);
        if (c == ChSpace || (c >= ChTab && c <= ChCr)) return ClsBlank;
        if (c >= ChZero && c <= ChNine) return ClsDigit;
        if (c == ChPlus) return ClsPlus;
        if (c == ChMinus) return ClsMinus;
        return ClsOther;
    endfunction

    // verdict on the side currently being read
    function automatic logic [1:0] side_verdict();
        if (phase == PhLead) return StBlank;
        if ((phase != PhDigits && phase != PhTrail) || too_big || (negative && magnitude != '0))
            return StInvalid;
        return StValid;
    endfunction

    task automatic clear_side_state();
        phase     = PhLead;
        negative  = 1'b0;
        magnitude = '0;
        too_big   = 1'b0;
    endtask

    task automatic restart_line();
        past_comma = 1'b0;
        src_status = StBlank;
        src_value  = '0;
        clear_side_state();
    endtask

    task automatic advance_char(input logic [7:0] c);
        char_class_t     cls;
        longint unsigned stepped;
        cls = classify(c);
        case (phase)
            PhLead: begin
                case (cls)
                    ClsBlank: ;
                    ClsPlus:  phase = PhSign;
                    ClsMinus: begin
                        negative = 1'b1;
                        phase    = PhSign;
                    end
                    ClsDigit: begin
                        phase     = PhDigits;
                        magnitude = ValueWidth'(c - ChZero);
                    end
                    default:  phase = PhBad;
                endcase
            end
            PhSign: begin
                if (cls == ClsDigit) begin
                    phase     = PhDigits;
                    magnitude = ValueWidth'(c - ChZero);
                end else begin
                    phase = PhBad;
                end
            end
            PhDigits: begin
                if (cls == ClsDigit) begin
                    // saturate once past the largest positive int
                    stepped = 64'(magnitude) * 64'd10 + 64'(c - ChZero);
                    if (stepped > 64'(MaxMagnitude)) begin
                        too_big   = 1'b1;
                        magnitude = MaxMagnitude;
                    end else begin
                        magnitude = stepped[ValueWidth-1:0];
                    end
                end else if (cls == ClsBlank) begin
                    phase = PhTrail;
                end else begin
                    phase = PhBad;
                end
            end
            PhTrail: begin
                if (cls != ClsBlank) phase = PhBad;
            end
            default: phase = PhBad;
        endcase
    endtask

    // one accepted input word; an end-of-line word queues the line it closes
    task automatic take_word(input logic last, input logic [7:0] c);
        parsed_line_t line;
        typed_line_t  answer;
        logic [1:0]   dst_status;
        if (!last) begin
            // only the first comma splits; later ones are ordinary bad characters
            if (c == ChSeparator && !past_comma) begin
                src_status = side_verdict();
                src_value  = magnitude;
                past_comma = 1'b1;
                clear_side_state();
            end else begin
                advance_char(c);
            end
        end else begin
            line       = '0;
            dst_status = side_verdict();
            if (past_comma && src_status == StValid && dst_status != StInvalid) begin
                line.ok      = 1'b1;
                line.src     = src_value;
                line.has_dst = (dst_status == StValid);
                line.dst     = line.has_dst ? magnitude : '0;
            end
            answer = typed_answers.pop_front();
            expected_lines.push_back(answer.typed ? answer.want : line);
            restart_line();
        end
    endtask

    // ---------------------------------------------------------------- scoring

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            failures++;
        end
    endtask

    task automatic check_line();
        parsed_line_t want;
        lines_scored++;
        if (m_tuser[0] === 1'b1) valid_lines++;
        if (m_tuser[1] === 1'b1) dest_lines++;
        if (expected_lines.size() == 0) begin
            $error("result word with no line outstanding");
            failures++;
        end else begin
            want = expected_lines.pop_front();
            compare_field("line_valid",   64'(want.ok),      64'(m_tuser[0]));
            compare_field("source_value", 64'(want.src),     64'(m_tdata[30:0]));
            compare_field("dest_present", 64'(want.has_dst), 64'(m_tuser[1]));
            compare_field("dest_value",   64'(want.dst),     64'(m_tdata[61:31]));
            compare_field("m_tdata pad",  64'd0,             64'(m_tdata[63:62]));
        end
    endtask

    // monitor: both channels sampled at the edge, input side first
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) take_word(s_tlast, s_tdata);
            if (m_tvalid && m_tready) check_line();
        end
    end

    // receiver: random back-pressure except in the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= IdlePercent);
    end

    // ---------------------------------------------------------------- stimulus helpers

    // TAB, LF, VT, FF, CR or space
    function automatic logic [7:0] blank_pick();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 5) ? ChSpace : ChTab + 8'(k);
    endfunction

    // mostly parser-relevant bytes, with plenty of arbitrary ones
    function automatic logic [7:0] noise_char();
        case ($urandom_range(0, 5))
            0, 1:    return 8'($urandom_range(0, 255));
            2:       return ChZero + 8'($urandom_range(0, 9));
            3:       return ChSeparator;
            4:       return $urandom_range(0, 1) ? ChPlus : ChMinus;
            default: return blank_pick();
        endcase
    endfunction

    task automatic push_blanks(input int unsigned n);
        repeat (n) line_chars.push_back(blank_pick());
    endtask

    // one side of a line: blanks, optional sign, digits biased to the edges of int
    task automatic push_number();
        longint unsigned v;
        string           digits;
        push_blanks($urandom_range(0, 2));
        case ($urandom_range(0, 7))
            0:       line_chars.push_back(ChPlus);
            1:       line_chars.push_back(ChMinus);
            default: ;
        endcase
        if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) line_chars.push_back(ChZero);
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = 64'(MaxMagnitude);
            2:       v = 64'(MaxMagnitude) + 1;
            3:       v = $urandom_range(0, 9);
            4, 5:    v = $urandom_range(0, 99999);
            6, 7:    v = 64'($urandom) & 64'(MaxMagnitude);
            8:       v = 64'($urandom);
            default: v = {$urandom, $urandom};  // far past the limit
        endcase
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) line_chars.push_back(digits[i]);
        push_blanks($urandom_range(0, 2));
    endtask

    // drive one word and hold it until the parser takes it
    task automatic send_word(input logic last, input logic [7:0] ch, input logic typed,
                             input parsed_line_t want);
        while (!steady && $urandom_range(0, 99) < IdlePercent) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        if (last) typed_answers.push_back({typed, want});
        s_tvalid <= 1'b1;
        s_tlast  <= last;
        s_tdata  <= ch;
        words_sent++;
        steady   <= (words_sent >= SteadyFrom && words_sent < SteadyTo);
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic stim_row_t ch_row(input logic [7:0] c);
        stim_row_t r;
        r    = '0;
        r.ch = c;
        return r;
    endfunction

    // end-of-line row; the character rides along and must be ignored
    function automatic stim_row_t end_row(input logic typed, input logic ok,
                                          input int unsigned src, input logic has_dst,
                                          input int unsigned dst);
        stim_row_t r;
        r              = '0;
        r.last         = 1'b1;
        r.ch           = ChSeparator;
        r.typed        = typed;
        r.want.ok      = ok;
        r.want.src     = ValueWidth'(src);
        r.want.has_dst = has_dst;
        r.want.dst     = ValueWidth'(dst);
        return r;
    endfunction

    // ---------------------------------------------------------------- main sequence

    initial begin
        stim_row_t rows [DirectedRows];
        int        pick;
        int        random_words;
        random_words = 0;
        restart_line();

        rows = '{
            // empty line
            end_row(1'b1, 1'b0, 0, 1'b0, 0),
            // no comma at all, top-bit byte
            ch_row(8'hFF), end_row(1'b1, 1'b0, 0, 1'b0, 0),
            // blank source
            ch_row(ChSeparator), end_row(1'b1, 1'b0, 0, 1'b0, 0),
            // minus zero reads as zero, explicit plus on the destination
            ch_row(ChMinus), ch_row(ChZero), ch_row(ChSeparator),
            ch_row(ChPlus), ch_row(ChNine), end_row(1'b1, 1'b1, 0, 1'b1, 9),
            // sign with no digits, closed by a second comma
            ch_row(ChZero + 8'd1), ch_row(ChSeparator), ch_row(ChMinus),
            ch_row(ChSeparator), end_row(1'b1, 1'b0, 0, 1'b0, 0),
            // NUL in the source
            ch_row(8'h00), ch_row(ChSeparator), end_row(1'b1, 1'b0, 0, 1'b0, 0),
            // negative non-zero
            ch_row(ChMinus), ch_row(ChZero + 8'd5), ch_row(ChSeparator),
            end_row(1'b1, 1'b0, 0, 1'b0, 0),
            // padded source, blank destination: left to the parser model
            ch_row(ChTab), ch_row(ChZero + 8'd3), ch_row(ChSpace), ch_row(ChSeparator),
            ch_row(ChCr), end_row(1'b0, 1'b0, 0, 1'b0, 0)
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) send_word(rows[i].last, rows[i].ch, rows[i].typed, rows[i].want);

        // random lines: mostly well-formed pairs, some corrupted, some one-sided, some noise
        while (random_words < RandomWords) begin
            line_chars.delete();
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                push_number();
                line_chars.push_back(ChSeparator);
                if ($urandom_range(0, 9) < 3) push_blanks($urandom_range(0, 3));
                else push_number();
                // one byte knocked out of an otherwise good line
                if (pick >= 60) line_chars[$urandom_range(0, line_chars.size() - 1)] = noise_char();
            end else if (pick < 75) begin
                push_number();
            end else if (pick < 80) begin
                push_blanks($urandom_range(0, 2));
                line_chars.push_back(ChSeparator);
                push_number();
            end else begin
                repeat ($urandom_range(0, 10)) line_chars.push_back(noise_char());
            end
            foreach (line_chars[i]) send_word(1'b0, line_chars[i], 1'b0, '0);
            send_word(1'b1, 8'($urandom_range(0, 255)), 1'b0, '0);
            random_words += line_chars.size() + 1;
        end
        s_tvalid <= 1'b0;

        while (expected_lines.size() != 0) @(posedge aclk);
        repeat (DrainCycles) @(posedge aclk);

        $display("Sent %0d words; scored %0d lines, %0d valid, %0d with a destination.",
                 words_sent, lines_scored, valid_lines, dest_lines);
        if (failures == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    // watchdog
    initial begin
        #(ClkPeriod * TimeoutCycles);
        $error("timed out with %0d lines outstanding", expected_lines.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
